/* src/lobm_pkg.sv */
// Shared types, codes and defaults for the limit order book matcher.
package lobm_pkg;

    localparam int ORDER_SLOTS_DEF = 32;

    localparam logic [1:0] OP_LIMIT  = 2'd0;
    localparam logic [1:0] OP_MARKET = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] KIND_TRADE       = 3'd0;
    localparam logic [2:0] KIND_DONE        = 3'd1;
    localparam logic [2:0] KIND_CANCEL_DONE = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND   = 3'd3;
    localparam logic [2:0] KIND_BOOK_FULL   = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic        side;
        logic [31:0] price;
        logic signed [31:0] quantity;
        logic [31:0] order_id;
        logic [63:0] timestamp;
    } lobm_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] maker_id;
        logic [31:0] aggressor_id;
        logic [31:0] trade_price;
        logic [30:0] amount;
        logic        aggressor_side;
        logic [31:0] sequence_res;
        logic [63:0] trade_time;
        logic        last;
        logic [31:0] top_bid;
        logic [31:0] top_ask;
        logic [1:0]  book_flags;
    } lobm_out_t;

    // one resting order as held in the slot memory
    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [30:0] remaining;
        logic [31:0] id;
        logic [31:0] arrival;
    } slot_t;

    // buffered result, before the book summary is known
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] maker_id;
        logic [31:0] aggressor_id;
        logic [31:0] trade_price;
        logic [30:0] amount;
        logic        aggressor_side;
        logic [31:0] sequence_res;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_FINAL,
        ST_BOOK,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_HOLD
    } state_t;

endpackage

/* src/lobm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* src/limit_order_book_matcher_core.sv */
// Top level: price-time priority matching engine over a slot memory of resting orders.
// Resting orders live in a one-read-port slot memory that is walked one entry a cycle.
// A limit or market order scans the slots for the best maker and fills against it,
// repeating the scan and fill until a scan finds no maker or a fill uses up the
// quantity. The step is then closed, the book summary scan runs over every slot, and
// each result beat is fetched, loaded, then held until the output is taken. A cancel
// runs one search, closes the step, runs the summary scan and emits its beats alike.
// An order with zero or negative quantity skips matching. Results are buffered and
// released only after the step, since every beat carries the best bid and ask that
// stand after it. One item is in work at a time; order_ready is high only when idle.
module limit_order_book_matcher_core #(
    parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                order_valid,
    output logic                order_ready,
    input  lobm_pkg::lobm_in_t  order,
    output logic                result_valid,
    input  logic                result_ready,
    output lobm_pkg::lobm_out_t result
);
    import lobm_pkg::*;

    localparam int AW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam int RD = ORDER_SLOTS + 1;
    localparam int RW = $clog2(RD);
    localparam int NW = $clog2(RD + 1);
    localparam int SW = $bits(slot_t);
    localparam int RSW = $bits(res_t);

    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic              side_reg, side_next;
    logic [31:0]       limit_reg, limit_next;
    logic [31:0]       cid_reg, cid_next;
    logic [63:0]       time_reg, time_next;
    logic [31:0]       tid_reg, tid_next;
    logic [30:0]       rem_reg, rem_next;
    logic [31:0]       next_id_reg, next_id_next;
    logic [31:0]       seq_reg, seq_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              have_best_reg, have_best_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    slot_t             best_reg, best_next;
    logic [31:0]       best_age_reg, best_age_next;
    logic              free_found_reg, free_found_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    logic              have_bid_reg, have_bid_next;
    logic [31:0]       bid_reg, bid_next;
    logic              have_ask_reg, have_ask_next;
    logic [31:0]       ask_reg, ask_next;
    logic [NW-1:0]     n_res_reg, n_res_next;
    logic [NW-1:0]     emit_reg, emit_next;
    lobm_out_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [ORDER_SLOTS-1:0] valid_reg, valid_next;

    logic              slot_we;
    logic [AW-1:0]     slot_waddr;
    slot_t             slot_wdata;
    logic [SW-1:0]     slot_rdata;
    logic              res_we;
    logic [RW-1:0]     res_waddr;
    res_t              res_wdata;
    logic [RW-1:0]     res_raddr;
    logic [RSW-1:0]    res_rdata;

    slot_t             rd;
    res_t              rres;
    logic [AW-1:0]     e_idx;
    logic              e_valid;
    logic              eval_active;
    logic              scan_end;
    logic              price_ok;
    logic              cand;
    logic              better;
    logic [31:0]       age;
    logic [30:0]       fill;
    logic [30:0]       rem_after;

    lobm_ram #(.WIDTH(SW), .DEPTH(ORDER_SLOTS)) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (slot_rdata)
    );

    lobm_ram #(.WIDTH(RSW), .DEPTH(RD)) u_results (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    assign order_ready  = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            next_id_reg    <= 32'd1;
            seq_reg        <= 32'd0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            n_res_reg      <= '0;
            emit_reg       <= '0;
            have_best_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            have_bid_reg   <= 1'b0;
            have_ask_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_id_reg    <= next_id_next;
            seq_reg        <= seq_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            n_res_reg      <= n_res_next;
            emit_reg       <= emit_next;
            have_best_reg  <= have_best_next;
            free_found_reg <= free_found_next;
            have_bid_reg   <= have_bid_next;
            have_ask_reg   <= have_ask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        side_reg     <= side_next;
        limit_reg    <= limit_next;
        cid_reg      <= cid_next;
        time_reg     <= time_next;
        tid_reg      <= tid_next;
        rem_reg      <= rem_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        free_idx_reg <= free_idx_next;
        bid_reg      <= bid_next;
        ask_reg      <= ask_next;
        out_reg      <= out_next;
    end

    // entry under evaluation is the one read in the previous cycle
    always_comb
    begin
        rd          = slot_t'(slot_rdata);
        rres        = res_t'(res_rdata);
        e_idx       = (cnt_reg != '0) ? AW'(cnt_reg - CW'(1)) : '0;
        e_valid     = valid_reg[e_idx];
        eval_active = (cnt_reg != '0);
        scan_end    = (cnt_reg == CW'(ORDER_SLOTS));
        if (op_reg == OP_MARKET)
        begin
            price_ok = 1'b1;
        end
        else if (!side_reg)
        begin
            price_ok = rd.price <= limit_reg;
        end
        else
        begin
            price_ok = rd.price >= limit_reg;
        end
        cand = e_valid && (rd.side != side_reg) && price_ok;
        age  = seq_reg - rd.arrival;
        if (!have_best_reg)
        begin
            better = 1'b1;
        end
        else if (rd.price != best_reg.price)
        begin
            better = side_reg ? (rd.price > best_reg.price) : (rd.price < best_reg.price);
        end
        else
        begin
            better = age > best_age_reg;
        end
        fill      = (rem_reg < best_reg.remaining) ? rem_reg : best_reg.remaining;
        rem_after = rem_reg - fill;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        side_next       = side_reg;
        limit_next      = limit_reg;
        cid_next        = cid_reg;
        time_next       = time_reg;
        tid_next        = tid_reg;
        rem_next        = rem_reg;
        next_id_next    = next_id_reg;
        seq_next        = seq_reg;
        cnt_next        = cnt_reg;
        have_best_next  = have_best_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        best_age_next   = best_age_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        have_bid_next   = have_bid_reg;
        bid_next        = bid_reg;
        have_ask_next   = have_ask_reg;
        ask_next        = ask_reg;
        n_res_next      = n_res_reg;
        emit_next       = emit_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        valid_next      = valid_reg;
        slot_we         = 1'b0;
        slot_waddr      = best_idx_reg;
        slot_wdata      = best_reg;
        res_we          = 1'b0;
        res_waddr       = n_res_reg[RW-1:0];
        res_wdata       = '0;
        res_raddr       = emit_reg[RW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (order_valid)
                begin
                    op_next         = order.operation;
                    side_next       = order.side;
                    limit_next      = order.price;
                    cid_next        = order.order_id;
                    time_next       = order.timestamp;
                    rem_next        = order.quantity[31] ? '0 : order.quantity[30:0];
                    n_res_next      = '0;
                    cnt_next        = '0;
                    have_best_next  = 1'b0;
                    free_found_next = 1'b0;
                    case (order.operation)
                        OP_CANCEL:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_LIMIT, OP_MARKET:
                        begin
                            tid_next     = next_id_reg;
                            next_id_next = next_id_reg + 32'd1;
                            state_next   = order.quantity[31] || order.quantity == '0
                                           ? ST_FINAL : ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (eval_active)
                begin
                    if (op_reg == OP_CANCEL)
                    begin
                        if (e_valid && rd.id == cid_reg && !have_best_reg)
                        begin
                            have_best_next = 1'b1;
                            best_idx_next  = e_idx;
                        end
                    end
                    else
                    begin
                        if (cand && better)
                        begin
                            have_best_next = 1'b1;
                            best_idx_next  = e_idx;
                            best_next      = rd;
                            best_age_next  = age;
                        end
                        if (!e_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = e_idx;
                        end
                    end
                end
                if (scan_end)
                begin
                    if (op_reg != OP_CANCEL && have_best_next)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_FINAL;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_FILL:
            begin
                slot_we              = 1'b1;
                slot_waddr           = best_idx_reg;
                slot_wdata           = best_reg;
                slot_wdata.remaining = best_reg.remaining - fill;
                if (best_reg.remaining == fill)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                end
                res_we                   = 1'b1;
                res_wdata.kind           = KIND_TRADE;
                res_wdata.maker_id       = best_reg.id;
                res_wdata.aggressor_id   = tid_reg;
                res_wdata.trade_price    = best_reg.price;
                res_wdata.amount         = fill;
                res_wdata.aggressor_side = side_reg;
                res_wdata.sequence_res   = seq_reg;
                n_res_next      = n_res_reg + NW'(1);
                seq_next        = seq_reg + 32'd1;
                rem_next        = rem_after;
                cnt_next        = '0;
                have_best_next  = 1'b0;
                free_found_next = 1'b0;
                state_next      = (rem_after == '0) ? ST_FINAL : ST_SCAN;
            end

            ST_FINAL:
            begin
                res_we     = 1'b1;
                n_res_next = n_res_reg + NW'(1);
                if (op_reg == OP_CANCEL)
                begin
                    res_wdata.aggressor_id = cid_reg;
                    if (have_best_reg)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        res_wdata.kind = KIND_CANCEL_DONE;
                    end
                    else
                    begin
                        res_wdata.kind = KIND_NOT_FOUND;
                    end
                end
                else
                begin
                    res_wdata.aggressor_id   = tid_reg;
                    res_wdata.aggressor_side = side_reg;
                    res_wdata.kind           = KIND_DONE;
                    if (op_reg == OP_LIMIT && rem_reg != '0)
                    begin
                        res_wdata.amount = rem_reg;
                        if (free_found_reg)
                        begin
                            slot_we                   = 1'b1;
                            slot_waddr                = free_idx_reg;
                            slot_wdata.side           = side_reg;
                            slot_wdata.price          = limit_reg;
                            slot_wdata.remaining      = rem_reg;
                            slot_wdata.id             = tid_reg;
                            slot_wdata.arrival        = seq_reg;
                            valid_next[free_idx_reg]  = 1'b1;
                            seq_next                  = seq_reg + 32'd1;
                        end
                        else
                        begin
                            res_wdata.kind = KIND_BOOK_FULL;
                        end
                    end
                end
                cnt_next      = '0;
                have_bid_next = 1'b0;
                have_ask_next = 1'b0;
                state_next    = ST_BOOK;
            end

            ST_BOOK:
            begin
                if (eval_active && e_valid)
                begin
                    if (!rd.side)
                    begin
                        if (!have_bid_reg || rd.price > bid_reg)
                        begin
                            bid_next = rd.price;
                        end
                        have_bid_next = 1'b1;
                    end
                    else
                    begin
                        if (!have_ask_reg || rd.price < ask_reg)
                        begin
                            ask_next = rd.price;
                        end
                        have_ask_next = 1'b1;
                    end
                end
                if (scan_end)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LOAD;
            end

            ST_EMIT_LOAD:
            begin
                out_next.kind           = rres.kind;
                out_next.maker_id       = rres.maker_id;
                out_next.aggressor_id   = rres.aggressor_id;
                out_next.trade_price    = rres.trade_price;
                out_next.amount         = rres.amount;
                out_next.aggressor_side = rres.aggressor_side;
                out_next.sequence_res   = rres.sequence_res;
                out_next.trade_time     = time_reg;
                out_next.last           = (emit_reg == NW'(n_res_reg - NW'(1)));
                out_next.top_bid        = have_bid_reg ? bid_reg : '0;
                out_next.top_ask        = have_ask_reg ? ask_reg : '0;
                out_next.book_flags     = {have_ask_reg, have_bid_reg};
                out_valid_next          = 1'b1;
                state_next              = ST_EMIT_HOLD;
            end

            ST_EMIT_HOLD:
            begin
                if (result_ready)
                begin
                    out_valid_next = 1'b0;
                    emit_next      = emit_reg + NW'(1);
                    state_next     = out_reg.last ? ST_IDLE : ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a result beat is shown only in the hold state
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> state_reg == ST_EMIT_HOLD)
        else $error("result beat outside hold state");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        order_ready |-> !result_valid)
        else $error("input taken while results pending");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_res_reg <= NW'(RD))
        else $error("result buffer overrun");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last |=> state_reg == ST_IDLE)
        else $error("step did not end after last beat");

endmodule

/* tb/tb.sv */
// Testbench for the limit order book matcher: directed and random orders checked beat by beat.
module tb;
    import lobm_pkg::*;

    localparam int SLOTS = ORDER_SLOTS_DEF;
    localparam int IDLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic order_valid = 1'b0;
    logic order_ready;
    lobm_in_t order = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    lobm_out_t result;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int idle_cycles = 0;

    lobm_out_t beats_due[$];

    // book model
    logic        bk_valid [SLOTS];
    logic        bk_side [SLOTS];
    logic [31:0] bk_price [SLOTS];
    logic [30:0] bk_rem [SLOTS];
    logic [31:0] bk_id [SLOTS];
    logic [31:0] bk_arr [SLOTS];
    logic [31:0] id_next;
    logic [31:0] seq_next;

    limit_order_book_matcher_core #(.ORDER_SLOTS(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .order_valid(order_valid), .order_ready(order_ready), .order(order),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    always #5 clk = ~clk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic lobm_out_t mk(input logic [2:0] k, input logic [31:0] mkr,
                                     input logic [31:0] tkr, input logic [31:0] pr,
                                     input logic [30:0] amt, input logic sd,
                                     input logic [31:0] sq, input logic [63:0] ts);
        lobm_out_t r;
        r = '0;
        r.kind = k; r.maker_id = mkr; r.aggressor_id = tkr; r.trade_price = pr;
        r.amount = amt; r.aggressor_side = sd; r.sequence_res = sq; r.trade_time = ts;
        return r;
    endfunction

    // applies one order to the book model and queues the beats it causes
    task automatic predict_book(input lobm_in_t it);
        lobm_out_t step_beats [SLOTS+1];
        int n_beats;
        logic [31:0] tid, bid, ask;
        logic [31:0] rem, fill;
        logic have_bid, have_ask, ok, better;
        int hit, best, fs;
        n_beats = 0;
        have_bid = 1'b0; have_ask = 1'b0; bid = '0; ask = '0;
        if (it.operation == OP_NONE) return;
        if (it.operation == OP_CANCEL) begin
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && bk_valid[i] && bk_id[i] == it.order_id) hit = i;
            if (hit >= 0) bk_valid[hit] = 1'b0;
            step_beats[n_beats] = mk(hit >= 0 ? KIND_CANCEL_DONE : KIND_NOT_FOUND, '0,
                                     it.order_id, '0, '0, 1'b0, '0, it.timestamp);
            n_beats++;
        end else begin
            tid = id_next;
            rem = it.quantity[31] ? 32'd0 : it.quantity;
            id_next++;
            while (rem > 0) begin
                best = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!bk_valid[i] || bk_side[i] == it.side) continue;
                    if (it.operation == OP_MARKET) ok = 1'b1;
                    else if (!it.side) ok = bk_price[i] <= it.price;
                    else ok = bk_price[i] >= it.price;
                    if (!ok) continue;
                    if (best < 0) begin best = i; continue; end
                    if (bk_price[i] != bk_price[best]) begin
                        better = !it.side ? bk_price[i] < bk_price[best]
                                          : bk_price[i] > bk_price[best];
                        if (better) best = i;
                    end else if (32'(seq_next - bk_arr[i]) > 32'(seq_next - bk_arr[best]))
                        best = i;
                end
                if (best < 0) break;
                fill = rem < bk_rem[best] ? rem : {1'b0, bk_rem[best]};
                step_beats[n_beats] = mk(KIND_TRADE, bk_id[best], tid, bk_price[best],
                                         fill[30:0], it.side, seq_next, it.timestamp);
                n_beats++;
                seq_next++;
                rem -= fill;
                bk_rem[best] -= fill[30:0];
                if (bk_rem[best] == 0) bk_valid[best] = 1'b0;
            end
            if (it.operation == OP_LIMIT && rem > 0) begin
                fs = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (fs < 0 && !bk_valid[i]) fs = i;
                if (fs < 0)
                    step_beats[n_beats] = mk(KIND_BOOK_FULL, '0, tid, '0, rem[30:0], it.side,
                                             '0, it.timestamp);
                else begin
                    bk_valid[fs] = 1'b1; bk_side[fs] = it.side; bk_price[fs] = it.price;
                    bk_rem[fs] = rem[30:0]; bk_id[fs] = tid; bk_arr[fs] = seq_next;
                    seq_next++;
                    step_beats[n_beats] = mk(KIND_DONE, '0, tid, '0, rem[30:0], it.side, '0,
                                             it.timestamp);
                end
            end else
                step_beats[n_beats] = mk(KIND_DONE, '0, tid, '0, '0, it.side, '0,
                                         it.timestamp);
            n_beats++;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!bk_valid[i]) continue;
            if (!bk_side[i]) begin
                if (!have_bid || bk_price[i] > bid) bid = bk_price[i];
                have_bid = 1'b1;
            end else begin
                if (!have_ask || bk_price[i] < ask) ask = bk_price[i];
                have_ask = 1'b1;
            end
        end
        for (int k = 0; k < n_beats; k++) begin
            step_beats[k].last = (k == n_beats - 1);
            step_beats[k].top_bid = bid;
            step_beats[k].top_ask = ask;
            step_beats[k].book_flags = {have_ask, have_bid};
            beats_due = {beats_due, step_beats[k]};
        end
    endtask

    // valid stays high across back to back beats and drops only while idling
    task automatic send_order(input lobm_in_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            order_valid <= 1'b0;
            @(posedge clk);
        end
        order <= it;
        order_valid <= 1'b1;
        predict_book(it);
        do @(posedge clk); while (!order_ready);
    endtask

    function automatic lobm_in_t make_order(input logic [1:0] op, input logic sd,
                                            input logic [31:0] pr, input logic [31:0] q,
                                            input logic [31:0] oid);
        lobm_in_t it;
        it.operation = op; it.side = sd; it.price = pr; it.quantity = q;
        it.order_id = oid; it.timestamp = {$urandom, $urandom};
        return it;
    endfunction

    task automatic drain_results();
        order_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    // receiver and checker
    always @(posedge clk) begin
        lobm_out_t w;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (beats_due.size() == 0) report("unexpected beat", 64'(result.kind), '0);
                else begin
                    w = beats_due[0];
                    beats_due.delete(0);
                    if (result.kind !== w.kind)
                        report("kind", 64'(result.kind), 64'(w.kind));
                    if (result.maker_id !== w.maker_id)
                        report("maker_id", 64'(result.maker_id), 64'(w.maker_id));
                    if (result.aggressor_id !== w.aggressor_id)
                        report("aggressor_id", 64'(result.aggressor_id), 64'(w.aggressor_id));
                    if (result.trade_price !== w.trade_price)
                        report("trade_price", 64'(result.trade_price), 64'(w.trade_price));
                    if (result.amount !== w.amount)
                        report("amount", 64'(result.amount), 64'(w.amount));
                    if (result.aggressor_side !== w.aggressor_side)
                        report("aggressor_side", 64'(result.aggressor_side),
                               64'(w.aggressor_side));
                    if (result.sequence_res !== w.sequence_res)
                        report("sequence_res", 64'(result.sequence_res), 64'(w.sequence_res));
                    if (result.trade_time !== w.trade_time)
                        report("trade_time", result.trade_time, w.trade_time);
                    if (result.last !== w.last)
                        report("last", 64'(result.last), 64'(w.last));
                    if (result.top_bid !== w.top_bid)
                        report("top_bid", 64'(result.top_bid), 64'(w.top_bid));
                    if (result.top_ask !== w.top_ask)
                        report("top_ask", 64'(result.top_ask), 64'(w.top_ask));
                    if (result.book_flags !== w.book_flags)
                        report("book_flags", 64'(result.book_flags), 64'(w.book_flags));
                end
            end
            result_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk) begin
        if ((order_valid && order_ready) || (result_valid && result_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        send_order(make_order(OP_CANCEL, 1'b0, 32'd0, 32'd0, 32'd5));
        send_order(make_order(OP_LIMIT, 1'b0, 32'd100, 32'd10, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b0, 32'd100, 32'd5, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b0, 32'd101, 32'd3, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b1, 32'd99, 32'd12, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF));
        send_order(make_order(OP_LIMIT, 1'b0, 32'd0, 32'h80000000, 32'd0));
        send_order(make_order(OP_MARKET, 1'b1, 32'd0, 32'd0, 32'd0));
        send_order(make_order(OP_MARKET, 1'b0, 32'hFFFFFFFF, 32'd7, 32'd0));
        send_order(make_order(OP_NONE, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_order(make_order(OP_CANCEL, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd3));
        send_order(make_order(OP_CANCEL, 1'b0, 32'd0, 32'd0, 32'd3));
        send_order(make_order(OP_MARKET, 1'b1, 32'd0, 32'h7FFFFFFF, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b0, 32'd0, 32'd1, 32'd0));
        send_order(make_order(OP_LIMIT, 1'b1, 32'd0, 32'h7FFFFFFF, 32'd0));
        send_order(make_order(OP_CANCEL, 1'b0, 32'd0, 32'd0, 32'd6));
    endtask

    // fill every slot with crossing-free buy limits, overflow twice, then sweep with a market sell
    task automatic test_book_full();
        for (int i = 0; i < SLOTS + 2; i++)
            send_order(make_order(OP_LIMIT, 1'b0, 32'd10 + $urandom_range(3),
                                  $urandom_range(1, 9), 32'd0));
        send_order(make_order(OP_MARKET, 1'b1, 32'd0, 32'h7FFFFFFF, 32'd0));
    endtask

    task automatic test_random(input int n);
        logic [1:0] op;
        logic [31:0] q, pr, oid;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: op = OP_LIMIT;
                5, 6: op = OP_MARKET;
                7, 8: op = OP_CANCEL;
                default: op = OP_NONE;
            endcase
            pr = ($urandom_range(9) == 0) ? $urandom : 32'd1000 + $urandom_range(8);
            q = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 20);
            oid = ($urandom_range(3) == 0) ? $urandom : id_next - $urandom_range(1, 12);
            send_order(make_order(op, 1'($urandom_range(1)), pr, q, oid));
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            bk_valid[i] = 1'b0; bk_side[i] = 1'b0; bk_price[i] = '0;
            bk_rem[i] = '0; bk_id[i] = '0; bk_arr[i] = '0;
        end
        id_next = 32'd1;
        seq_next = 32'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_book_full();
        test_random(25);
        send_idle_pct = 48; recv_stall_pct = 0;
        test_random(25);
        send_idle_pct = 0; recv_stall_pct = 48;
        test_random(25);
        send_idle_pct = 9; recv_stall_pct = 9;
        test_random(25);
        send_idle_pct = 0; recv_stall_pct = 0;
        drain_results();
        if (error_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* files.f */
src/lobm_pkg.sv
src/lobm_ram.sv
src/limit_order_book_matcher_core.sv
tb/tb.sv
